// ----- src/usg_pkg.sv -----
// usg_pkg: shared types, constants and helper functions of the uv sphere generator
// depends on nothing; used by every module under src
`default_nettype none

package usg_pkg;

   localparam int MAX_DIVISIONS = 1024;

   localparam logic [10:0] MAX_CNT = (MAX_DIVISIONS > 2047) ? 11'd2047 : 11'(MAX_DIVISIONS);
   localparam logic [10:0] MIN_SEGMENTS = 11'd3;
   localparam logic [10:0] MIN_RINGS = 11'd2;

   localparam logic [15:0] RESET_RADIUS = 16'd256;
   localparam logic [10:0] RESET_SEGMENTS = 11'd32;
   localparam logic [10:0] RESET_RINGS = 11'd16;

   // divider steps: fractional bits for longitude, latitude and texture taps
   localparam int U_STEPS = 32;
   localparam int V_STEPS = 31;
   localparam int TEX_STEP = 16;

   localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

   localparam logic [2:0] LAST_CORNER = 3'd5;

   typedef enum logic {
      KIND_VERTEX = 1'b0,
      KIND_QUAD   = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      CSR_RADIUS   = 2'd0,
      CSR_SEGMENTS = 2'd1,
      CSR_RINGS    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic        kind;
      logic        bad;
      logic [20:0] idx;
      logic [16:0] tex_u;
      logic [16:0] tex_v;
   } meta_type;

   typedef struct packed {
      meta_type    meta;
      logic [10:0] ru;
      logic [10:0] rv;
      logic [32:0] qu;
      logic [31:0] qv;
      logic [31:0] lat;
      logic [31:0] lon;
   } div_word_type;

   typedef struct packed {
      meta_type           meta;
      logic [1:0]         quad_lat;
      logic [1:0]         quad_lon;
      logic signed [33:0] xl;
      logic signed [33:0] yl;
      logic signed [32:0] zl;
      logic signed [33:0] xo;
      logic signed [33:0] yo;
      logic signed [32:0] zo;
   } cordic_word_type;

   typedef struct packed {
      meta_type           meta;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
   } norm_word_type;

   function automatic logic signed [32:0] atan_q30(input int step);
      logic signed [32:0] a;
      case (step)
         0:  a = 33'sd843314857;
         1:  a = 33'sd497837829;
         2:  a = 33'sd263043837;
         3:  a = 33'sd133525159;
         4:  a = 33'sd67021687;
         5:  a = 33'sd33543516;
         6:  a = 33'sd16775851;
         7:  a = 33'sd8388437;
         8:  a = 33'sd4194283;
         9:  a = 33'sd2097149;
         10: a = 33'sd1048576;
         11: a = 33'sd524288;
         12: a = 33'sd262144;
         13: a = 33'sd131072;
         14: a = 33'sd65536;
         15: a = 33'sd32768;
         16: a = 33'sd16384;
         17: a = 33'sd8192;
         18: a = 33'sd4096;
         19: a = 33'sd2048;
         20: a = 33'sd1024;
         21: a = 33'sd512;
         22: a = 33'sd256;
         23: a = 33'sd128;
         default: a = 33'sd0;
      endcase
      return a;
   endfunction

   // rounding carry of a long division: remainder plus half the divisor reaches the divisor
   function automatic logic round_up(input logic [10:0] rem, input logic [10:0] div);
      return ({1'b0, rem} + {2'b0, div[10:1]}) >= {1'b0, div};
   endfunction

   function automatic logic signed [15:0] sat14(input logic signed [63:0] v);
      logic signed [15:0] r;
      if (v > 64'sd16384) begin
         r = 16'sd16384;
      end else if (v < -64'sd16384) begin
         r = -16'sd16384;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- src/usg_div_cell.sv -----
// usg_div_cell: one restoring long-division step for longitude and latitude
// depends on usg_pkg
`default_nettype none

module usg_div_cell #(
   parameter int STEP = 1
) (
   input  wire logic                  clock,
   input  wire logic                  load,
   input  wire logic [10:0]           seg_div,
   input  wire logic [10:0]           ring_div,
   input  wire usg_pkg::div_word_type prev_word,
   output usg_pkg::div_word_type      word_out
);
   import usg_pkg::*;

   div_word_type word_ff, word_in;
   logic [11:0] u_shift, v_shift, u_sub, v_sub;
   logic        u_bit, v_bit;
   logic [10:0] ru_next, rv_next;

   always_comb begin
      word_in = prev_word;
      u_shift = {prev_word.ru, 1'b0};
      u_sub = u_shift - {1'b0, seg_div};
      u_bit = u_shift >= {1'b0, seg_div};
      ru_next = u_bit ? u_sub[10:0] : u_shift[10:0];
      word_in.ru = ru_next;
      word_in.qu = {prev_word.qu[31:0], u_bit};

      v_shift = {prev_word.rv, 1'b0};
      v_sub = v_shift - {1'b0, ring_div};
      v_bit = v_shift >= {1'b0, ring_div};
      rv_next = v_bit ? v_sub[10:0] : v_shift[10:0];
      if (STEP <= V_STEPS) begin
         word_in.rv = rv_next;
         word_in.qv = {prev_word.qv[30:0], v_bit};
      end

      // texture taps after sixteen fractional bits
      if (STEP == TEX_STEP) begin
         word_in.meta.tex_u = word_in.qu[16:0] + {16'd0, round_up(ru_next, seg_div)};
         word_in.meta.tex_v = word_in.qv[16:0] + {16'd0, round_up(rv_next, ring_div)};
      end
      if (STEP == V_STEPS) begin
         word_in.lat = word_in.qv + {31'd0, round_up(rv_next, ring_div)};
      end
      if (STEP == U_STEPS) begin
         word_in.lon = word_in.qu[31:0] + {31'd0, round_up(ru_next, seg_div)};
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign word_out = word_ff;

endmodule

`default_nettype wire

// ----- src/usg_cordic_cell.sv -----
// usg_cordic_cell: one rotation-mode cordic step for latitude and longitude
// depends on usg_pkg
`default_nettype none

module usg_cordic_cell #(
   parameter int STEP = 0
) (
   input  wire logic                     clock,
   input  wire logic                     load,
   input  wire usg_pkg::cordic_word_type prev_word,
   output usg_pkg::cordic_word_type      word_out
);
   import usg_pkg::*;

   cordic_word_type word_ff, word_in;
   logic signed [33:0] xl, yl, xo, yo, xl_sh, yl_sh, xo_sh, yo_sh;
   logic signed [32:0] zl, zo, angle;

   always_comb begin
      word_in = prev_word;
      xl = prev_word.xl;
      yl = prev_word.yl;
      zl = prev_word.zl;
      xo = prev_word.xo;
      yo = prev_word.yo;
      zo = prev_word.zo;
      xl_sh = xl >>> STEP;
      yl_sh = yl >>> STEP;
      xo_sh = xo >>> STEP;
      yo_sh = yo >>> STEP;
      angle = atan_q30(STEP);
      if (!zl[32]) begin
         word_in.xl = xl - yl_sh;
         word_in.yl = yl + xl_sh;
         word_in.zl = zl - angle;
      end else begin
         word_in.xl = xl + yl_sh;
         word_in.yl = yl - xl_sh;
         word_in.zl = zl + angle;
      end
      if (!zo[32]) begin
         word_in.xo = xo - yo_sh;
         word_in.yo = yo + xo_sh;
         word_in.zo = zo - angle;
      end else begin
         word_in.xo = xo + yo_sh;
         word_in.yo = yo - xo_sh;
         word_in.zo = zo + angle;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign word_out = word_ff;

endmodule

`default_nettype wire

// ----- src/usg_out_seq.sv -----
// usg_out_seq: position scaling, output register and six-corner quad sequencer
// depends on usg_pkg
`default_nettype none

module usg_out_seq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire usg_pkg::norm_word_type in_word,
   input  wire logic [15:0]            radius,
   input  wire logic [11:0]            row_len,
   output logic                        out_free,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic signed [16:0]          rsp_pos_x,
   output logic signed [16:0]          rsp_pos_y,
   output logic signed [16:0]          rsp_pos_z,
   output logic signed [15:0]          rsp_norm_x,
   output logic signed [15:0]          rsp_norm_y,
   output logic signed [15:0]          rsp_norm_z,
   output logic [16:0]                 rsp_tex_u,
   output logic [16:0]                 rsp_tex_v,
   output logic [20:0]                 rsp_vertex_index,
   output logic                        rsp_bad_request,
   output logic                        rsp_last
);
   import usg_pkg::*;

   logic               vo_ff;
   logic [2:0]         cnt_ff;
   meta_type           meta_ff;
   logic signed [16:0] px_ff, py_ff, pz_ff;
   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   logic [16:0]        tu_ff, tv_ff;

   logic               take, quad_ok, last_now, vertex_ok;
   logic signed [16:0] rad_s;
   logic signed [15:0] nx, ny, nz;
   logic signed [32:0] px_prod, py_prod, pz_prod, px_r, py_r, pz_r;
   logic [20:0]        tl, tr, bl, br;

   assign take = vo_ff && !rsp_stall;
   assign quad_ok = (meta_ff.kind == KIND_QUAD) && !meta_ff.bad;
   assign last_now = !quad_ok || (cnt_ff == LAST_CORNER);
   assign out_free = !vo_ff || (take && last_now);
   assign vertex_ok = (in_word.meta.kind == KIND_VERTEX) && !in_word.meta.bad;

   always_comb begin
      rad_s = signed'({1'b0, radius});
      nx = in_word.nx;
      ny = in_word.ny;
      nz = in_word.nz;
      px_prod = rad_s * nx;
      py_prod = rad_s * ny;
      pz_prod = rad_s * nz;
      px_r = (px_prod + 33'sd8192) >>> 14;
      py_r = (py_prod + 33'sd8192) >>> 14;
      pz_r = (pz_prod + 33'sd8192) >>> 14;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
         cnt_ff <= 3'd0;
      end else begin
         if (out_free) begin
            vo_ff <= in_valid;
            cnt_ff <= 3'd0;
         end else if (take) begin
            cnt_ff <= cnt_ff + 3'd1;
         end
      end
   end

   // payload, zeroed for quads and bad requests
   always_ff @(posedge clock) begin
      if (out_free) begin
         meta_ff <= in_word.meta;
         if (vertex_ok) begin
            px_ff <= px_r[16:0];
            py_ff <= py_r[16:0];
            pz_ff <= pz_r[16:0];
            nx_ff <= nx;
            ny_ff <= ny;
            nz_ff <= nz;
            tu_ff <= in_word.meta.tex_u;
            tv_ff <= in_word.meta.tex_v;
         end else begin
            px_ff <= '0;
            py_ff <= '0;
            pz_ff <= '0;
            nx_ff <= '0;
            ny_ff <= '0;
            nz_ff <= '0;
            tu_ff <= '0;
            tv_ff <= '0;
         end
      end
   end

   always_comb begin
      tl = meta_ff.idx;
      tr = tl + 21'd1;
      bl = tl + {9'd0, row_len};
      br = bl + 21'd1;
      rsp_vertex_index = '0;
      if (quad_ok) begin
         case (cnt_ff)
            3'd0:    rsp_vertex_index = tl;
            3'd1:    rsp_vertex_index = tr;
            3'd2:    rsp_vertex_index = br;
            3'd3:    rsp_vertex_index = tl;
            3'd4:    rsp_vertex_index = br;
            3'd5:    rsp_vertex_index = bl;
            default: rsp_vertex_index = '0;
         endcase
      end
   end

   assign rsp_valid = vo_ff;
   assign rsp_pos_x = px_ff;
   assign rsp_pos_y = py_ff;
   assign rsp_pos_z = pz_ff;
   assign rsp_norm_x = nx_ff;
   assign rsp_norm_y = ny_ff;
   assign rsp_norm_z = nz_ff;
   assign rsp_tex_u = tu_ff;
   assign rsp_tex_v = tv_ff;
   assign rsp_bad_request = meta_ff.bad;
   assign rsp_last = last_now;

endmodule

`default_nettype wire

// ----- src/uv_sphere_mesh_generator_top.sv -----
// uv_sphere_mesh_generator_top: uv sphere vertex and quad index generator
// depends on usg_pkg, usg_div_cell, usg_cordic_cell, usg_out_seq
//
//  channel | direction | handshake           | word
//  req     | in        | req_valid/req_stall | kind, ring_pos, seg_pos
//  rsp     | out       | rsp_valid/rsp_stall | position, normal, texture, index, flags
//  csr     | in        | csr_wr_en           | csr_index, csr_wdata
//
// one request taken per cycle while req_stall is low; a request passes through a row of
// 32 divider cells, CORDIC_STEPS cordic cells and four plain stages
// a vertex request gives one word; a quad gives six, holding the single output register
// until its sixth word is taken, so no new word enters the output register meanwhile
// reset is synchronous and clears the valid chain and loads the register defaults
// a stage moves on when its successor is empty or moving, so bubbles are squeezed out
`default_nettype none

module uv_sphere_mesh_generator_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_wr_en,
   input  wire logic [1:0]    csr_index,
   input  wire logic [15:0]   csr_wdata,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic          req_kind,
   input  wire logic [10:0]   req_ring_pos,
   input  wire logic [10:0]   req_seg_pos,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic signed [16:0] rsp_pos_x,
   output logic signed [16:0] rsp_pos_y,
   output logic signed [16:0] rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic [16:0]        rsp_tex_u,
   output logic [16:0]        rsp_tex_v,
   output logic [20:0]        rsp_vertex_index,
   output logic               rsp_bad_request,
   output logic               rsp_last
);
   import usg_pkg::*;

   // stage map: 0 input, 1..32 divider, 33 angle scale, then cordic, then fold
   localparam int ANGLE_ST = U_STEPS + 1;
   localparam int NMID = U_STEPS + CORDIC_STEPS + 3;
   localparam int FOLD_ST = NMID - 1;

   // configuration registers
   logic [15:0] radius_ff;
   logic [10:0] segments_ff, rings_ff;
   logic [10:0] seg_cnt, ring_cnt;
   logic [11:0] row_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RESET_RADIUS;
         segments_ff <= RESET_SEGMENTS;
         rings_ff <= RESET_RINGS;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RADIUS:   radius_ff <= csr_wdata;
            CSR_SEGMENTS: segments_ff <= csr_wdata[10:0];
            CSR_RINGS:    rings_ff <= csr_wdata[10:0];
            default:      ;
         endcase
      end
   end

   // effective grid size, clamped both ways
   always_comb begin
      if (segments_ff < MIN_SEGMENTS) begin
         seg_cnt = MIN_SEGMENTS;
      end else if (segments_ff > MAX_CNT) begin
         seg_cnt = MAX_CNT;
      end else begin
         seg_cnt = segments_ff;
      end
      if (rings_ff < MIN_RINGS) begin
         ring_cnt = MIN_RINGS;
      end else if (rings_ff > MAX_CNT) begin
         ring_cnt = MAX_CNT;
      end else begin
         ring_cnt = rings_ff;
      end
      row_len = {1'b0, seg_cnt} + 12'd1;
   end

   // valid chain and squeeze-out advance chain
   logic [NMID-1:0] v_ff;
   logic [NMID-1:0] free;
   logic            out_free;

   assign free[NMID-1] = !v_ff[NMID-1] || out_free;
   for (genvar gi = 0; gi < NMID - 1; gi++) begin : g_free
      assign free[gi] = !v_ff[gi] || free[gi+1];
   end

   assign req_stall = !free[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (free[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int i = 1; i < NMID; i++) begin
            if (free[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // stage 0: grid check, corner index, integer step of both divisions
   div_word_type word0_ff, word0_in;
   logic [22:0]  idx_prod;
   logic         u_int, v_int;

   always_comb begin
      word0_in = '0;
      word0_in.meta.kind = req_kind;
      if (req_kind == KIND_VERTEX) begin
         word0_in.meta.bad = (req_ring_pos > ring_cnt) || (req_seg_pos > seg_cnt);
      end else begin
         word0_in.meta.bad = (req_ring_pos >= ring_cnt) || (req_seg_pos >= seg_cnt);
      end
      idx_prod = req_ring_pos * row_len;
      word0_in.meta.idx = idx_prod[20:0] + {10'd0, req_seg_pos};
      u_int = req_seg_pos >= seg_cnt;
      v_int = req_ring_pos >= ring_cnt;
      word0_in.ru = u_int ? (req_seg_pos - seg_cnt) : req_seg_pos;
      word0_in.rv = v_int ? (req_ring_pos - ring_cnt) : req_ring_pos;
      word0_in.qu = {32'd0, u_int};
      word0_in.qv = {31'd0, v_int};
   end

   always_ff @(posedge clock) begin
      if (free[0]) begin
         word0_ff <= word0_in;
      end
   end

   // divider row: one quotient bit per cell
   div_word_type div_words [0:U_STEPS];
   assign div_words[0] = word0_ff;

   for (genvar gi = 1; gi <= U_STEPS; gi++) begin : g_div
      usg_div_cell #(
         .STEP(gi)
      ) u_div_cell (
         .clock    (clock),
         .load     (free[gi]),
         .seg_div  (seg_cnt),
         .ring_div (ring_cnt),
         .prev_word(div_words[gi-1]),
         .word_out (div_words[gi])
      );
   end

   // angle stage: turn fraction within quadrant to q2.30 radians
   cordic_word_type cord_words [0:CORDIC_STEPS];
   cordic_word_type angle_ff, angle_in;
   logic [60:0]     zl_prod, zo_prod, zl_sum, zo_sum;

   always_comb begin
      zl_prod = div_words[U_STEPS].lat[29:0] * HALF_PI_Q30;
      zo_prod = div_words[U_STEPS].lon[29:0] * HALF_PI_Q30;
      zl_sum = zl_prod + 61'd536870912;
      zo_sum = zo_prod + 61'd536870912;
      angle_in.meta = div_words[U_STEPS].meta;
      angle_in.quad_lat = div_words[U_STEPS].lat[31:30];
      angle_in.quad_lon = div_words[U_STEPS].lon[31:30];
      angle_in.xl = GAIN_Q30;
      angle_in.yl = '0;
      angle_in.zl = signed'({2'b00, zl_sum[60:30]});
      angle_in.xo = GAIN_Q30;
      angle_in.yo = '0;
      angle_in.zo = signed'({2'b00, zo_sum[60:30]});
   end

   always_ff @(posedge clock) begin
      if (free[ANGLE_ST]) begin
         angle_ff <= angle_in;
      end
   end

   assign cord_words[0] = angle_ff;

   // cordic row
   for (genvar gj = 0; gj < CORDIC_STEPS; gj++) begin : g_cordic
      usg_cordic_cell #(
         .STEP(gj)
      ) u_cordic_cell (
         .clock    (clock),
         .load     (free[ANGLE_ST+1+gj]),
         .prev_word(cord_words[gj]),
         .word_out (cord_words[gj+1])
      );
   end

   // fold stage: quadrant unfold, normal products, rounding to q1.14
   cordic_word_type    cw;
   norm_word_type      norm_ff, norm_in;
   logic signed [33:0] cp, sp, ct, st;
   logic signed [31:0] cp32, sp32, ct32, st32;
   logic signed [63:0] nx_prod, nz_prod, nx_sh, nz_sh;
   logic signed [32:0] cp_r, ny_sh;

   always_comb begin
      cw = cord_words[CORDIC_STEPS];
      unique case (cw.quad_lat)
         2'd0: begin cp = cw.xl;  sp = cw.yl;  end
         2'd1: begin cp = -cw.yl; sp = cw.xl;  end
         2'd2: begin cp = -cw.xl; sp = -cw.yl; end
         2'd3: begin cp = cw.yl;  sp = -cw.xl; end
      endcase
      unique case (cw.quad_lon)
         2'd0: begin ct = cw.xo;  st = cw.yo;  end
         2'd1: begin ct = -cw.yo; st = cw.xo;  end
         2'd2: begin ct = -cw.xo; st = -cw.yo; end
         2'd3: begin ct = cw.yo;  st = -cw.xo; end
      endcase
      cp32 = cp[31:0];
      sp32 = sp[31:0];
      ct32 = ct[31:0];
      st32 = st[31:0];
      nx_prod = sp32 * ct32;
      nz_prod = sp32 * st32;
      nx_sh = (nx_prod + 64'sd35184372088832) >>> 46;
      nz_sh = (nz_prod + 64'sd35184372088832) >>> 46;
      cp_r = {cp32[31], cp32} + 33'sd32768;
      ny_sh = cp_r >>> 16;
      norm_in.meta = cw.meta;
      norm_in.nx = sat14(nx_sh);
      norm_in.ny = sat14({{31{ny_sh[32]}}, ny_sh});
      norm_in.nz = sat14(nz_sh);
   end

   always_ff @(posedge clock) begin
      if (free[FOLD_ST]) begin
         norm_ff <= norm_in;
      end
   end

   // position scaling and the output word register
   usg_out_seq u_out_seq (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (v_ff[FOLD_ST]),
      .in_word         (norm_ff),
      .radius          (radius_ff),
      .row_len         (row_len),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_pos_z       (rsp_pos_z),
      .rsp_norm_x      (rsp_norm_x),
      .rsp_norm_y      (rsp_norm_y),
      .rsp_norm_z      (rsp_norm_z),
      .rsp_tex_u       (rsp_tex_u),
      .rsp_tex_v       (rsp_tex_v),
      .rsp_vertex_index(rsp_vertex_index),
      .rsp_bad_request (rsp_bad_request),
      .rsp_last        (rsp_last)
   );

   // a rejected request is always a single closing word
   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_request |-> rsp_last)
      else $error("bad request word not marked last");

   // index words carry no geometry
   a_index_no_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_vertex_index != 21'd0) |->
         (rsp_pos_x == 17'sd0) && (rsp_norm_y == 16'sd0) && (rsp_tex_u == 17'd0))
      else $error("index word carries geometry");

   // an empty input stage never pushes back
   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !v_ff[0] |-> !req_stall)
      else $error("input stalled with empty first stage");

   // a word that is held moves no stage of the row behind it when the row is full
   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && (&v_ff) |-> req_stall)
      else $error("request taken while the full row is held");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// tb: self-checking bench for the uv sphere vertex and quad index generator
// depends on usg_pkg and uv_sphere_mesh_generator_top; predicts every word itself
`timescale 1ns / 1ps

import usg_pkg::*;

// one result word as it leaves the block
typedef struct {
   logic signed [16:0] px, py, pz;
   logic signed [15:0] nx, ny, nz;
   logic [16:0]        tu, tv;
   logic [20:0]        idx;
   logic               bad, last;
} sphere_word_type;

class sphere_scoreboard;
   logic [15:0]     radius;
   logic [10:0]     seg_reg, ring_reg;
   sphere_word_type due[$];
   int              errors;

   function new();
      radius = RESET_RADIUS;
      seg_reg = RESET_SEGMENTS;
      ring_reg = RESET_RINGS;
      errors = 0;
   endfunction

   function void write_reg(logic [1:0] i, logic [15:0] d);
      if (i == CSR_RADIUS) radius = d;
      else if (i == CSR_SEGMENTS) seg_reg = d[10:0];
      else if (i == CSR_RINGS) ring_reg = d[10:0];
   endfunction

   static function longint sat_q14(longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
   endfunction

   // cordic on a turn fraction, q30 cosine and sine
   static function void turn_cos_sin(logic [31:0] turn, output longint c, output longint s);
      longint atans[16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                            524288, 262144, 131072, 65536, 32768};
      longint x, y, z, tx, ty;
      x = 652032874;
      y = 0;
      z = (longint'(turn[29:0]) * 64'd1686629713 + (longint'(1) << 29)) >>> 30;
      for (int i = 0; i < 16; i++) begin
         tx = x >>> i;
         ty = y >>> i;
         if (z >= 0) begin
            x = x - ty; y = y + tx; z = z - atans[i];
         end else begin
            x = x + ty; y = y - tx; z = z + atans[i];
         end
      end
      case (turn[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function void note_request(logic k, logic [10:0] ring, logic [10:0] seg);
      longint segs, rings, cp, sp, ct, st, n[3], rowlen, tl;
      logic [31:0] lat, lon;
      sphere_word_type w;
      segs = (seg_reg < MIN_SEGMENTS) ? MIN_SEGMENTS : (seg_reg > MAX_CNT) ? MAX_CNT : seg_reg;
      rings = (ring_reg < MIN_RINGS) ? MIN_RINGS : (ring_reg > MAX_CNT) ? MAX_CNT : ring_reg;
      w = '{default: 0};
      w.last = 1;
      if (kind_type'(k) == KIND_VERTEX) begin
         if (ring > rings || seg > segs) begin
            w.bad = 1;
            due.push_back(w);
            return;
         end
         lat = ((longint'(ring) << 31) + rings / 2) / rings;
         lon = ((longint'(seg) << 32) + segs / 2) / segs;
         turn_cos_sin(lat, cp, sp);
         turn_cos_sin(lon, ct, st);
         n[0] = sat_q14((sp * ct + (longint'(1) << 45)) >>> 46);
         n[1] = sat_q14((cp + (longint'(1) << 15)) >>> 16);
         n[2] = sat_q14((sp * st + (longint'(1) << 45)) >>> 46);
         w.nx = n[0]; w.ny = n[1]; w.nz = n[2];
         w.px = (longint'(radius) * n[0] + 8192) >>> 14;
         w.py = (longint'(radius) * n[1] + 8192) >>> 14;
         w.pz = (longint'(radius) * n[2] + 8192) >>> 14;
         w.tu = ((longint'(seg) << 16) + segs / 2) / segs;
         w.tv = ((longint'(ring) << 16) + rings / 2) / rings;
         due.push_back(w);
      end else begin
         if (ring >= rings || seg >= segs) begin
            w.bad = 1;
            due.push_back(w);
            return;
         end
         // two triangles: tl, tr, br, tl, br, bl
         rowlen = segs + 1;
         tl = ring * rowlen + seg;
         w.last = 0;
         w.idx = tl;               due.push_back(w);
         w.idx = tl + 1;           due.push_back(w);
         w.idx = tl + rowlen + 1;  due.push_back(w);
         w.idx = tl;               due.push_back(w);
         w.idx = tl + rowlen + 1;  due.push_back(w);
         w.idx = tl + rowlen; w.last = 1; due.push_back(w);
      end
   endfunction

   task report_mismatch(string field, longint got, longint want);
      errors++;
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
   endtask

   task check_word(sphere_word_type g);
      sphere_word_type e;
      if (due.size() == 0) begin
         report_mismatch("unexpected word", g.idx, -1);
         return;
      end
      e = due.pop_front();
      if (g.px !== e.px) report_mismatch("pos_x", g.px, e.px);
      if (g.py !== e.py) report_mismatch("pos_y", g.py, e.py);
      if (g.pz !== e.pz) report_mismatch("pos_z", g.pz, e.pz);
      if (g.nx !== e.nx) report_mismatch("norm_x", g.nx, e.nx);
      if (g.ny !== e.ny) report_mismatch("norm_y", g.ny, e.ny);
      if (g.nz !== e.nz) report_mismatch("norm_z", g.nz, e.nz);
      if (g.tu !== e.tu) report_mismatch("tex_u", g.tu, e.tu);
      if (g.tv !== e.tv) report_mismatch("tex_v", g.tv, e.tv);
      if (g.idx !== e.idx) report_mismatch("vertex_index", g.idx, e.idx);
      if (g.bad !== e.bad) report_mismatch("bad_request", g.bad, e.bad);
      if (g.last !== e.last) report_mismatch("last", g.last, e.last);
   endtask
endclass

module tb;
   localparam logic [1:0] CSR_SPARE = 2'd3;   // index with no register behind it
   localparam int DRAIN_CYCLES = 80;          // a little longer than the pipe
   localparam int CYCLE_LIMIT = 300000;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic req_valid = 0;
   logic req_stall;
   logic req_kind = 0;
   logic [10:0] req_ring_pos = '0, req_seg_pos = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [16:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [15:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic [16:0] rsp_tex_u, rsp_tex_v;
   logic [20:0] rsp_vertex_index;
   logic rsp_bad_request, rsp_last;

   sphere_scoreboard sb = new();
   int  cycles = 0;
   int  rsp_wait = 0;       // cycles the receiver still holds off
   int  long_hold = 0;      // one long stretch of back-pressure
   bit  calm = 0;           // no idling on either side while set

   uv_sphere_mesh_generator_top uut (.*);

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[uv_sphere_mesh_generator_top] ERROR");
         $finish;
      end
   end

   // requests taken by the block go to the predictor
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_request(req_kind, req_ring_pos, req_seg_pos);
   end

   // every accepted word is checked; then the receiver draws its next pause
   always @(posedge clock) begin
      sphere_word_type g;
      if (!reset && rsp_valid && !rsp_stall) begin
         g.px = rsp_pos_x; g.py = rsp_pos_y; g.pz = rsp_pos_z;
         g.nx = rsp_norm_x; g.ny = rsp_norm_y; g.nz = rsp_norm_z;
         g.tu = rsp_tex_u; g.tv = rsp_tex_v; g.idx = rsp_vertex_index;
         g.bad = rsp_bad_request; g.last = rsp_last;
         sb.check_word(g);
         rsp_wait = calm ? 0 : $urandom_range(0, 3);
      end
   end

   // receiver stall, long hold first, then the drawn pause
   always @(negedge clock) begin
      if (long_hold > 0) begin
         rsp_stall <= 1;
         long_hold--;
      end else if (rsp_wait > 0) begin
         rsp_stall <= 1;
         rsp_wait--;
      end else begin
         rsp_stall <= 0;
      end
   end

   task write_csr(logic [1:0] i, logic [15:0] d);
      @(negedge clock);
      csr_wr_en <= 1;
      csr_index <= i;
      csr_wdata <= d;
      sb.write_reg(i, d);
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   // offer one request word, after a random gap, until it is taken
   task send_request(logic k, logic [10:0] ring, logic [10:0] seg);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_kind <= k;
      req_ring_pos <= ring;
      req_seg_pos <= seg;
      do @(posedge clock); while (req_stall);
   endtask

   // wait for every expected word, then let the pipe go quiet
   task drain;
      @(negedge clock);
      req_valid <= 0;
      while (sb.due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // mostly in-grid requests sized to the current settings, some anywhere
   task random_items(int count);
      int segs, rings;
      logic [10:0] r, s;
      segs = (sb.seg_reg < 3) ? 3 : (sb.seg_reg > 1024) ? 1024 : sb.seg_reg;
      rings = (sb.ring_reg < 2) ? 2 : (sb.ring_reg > 1024) ? 1024 : sb.ring_reg;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0) begin
            r = 11'($urandom_range(0, 2047));
            s = 11'($urandom_range(0, 2047));
         end else begin
            r = 11'($urandom_range(0, rings));
            s = 11'($urandom_range(0, segs));
         end
         send_request(1'($urandom_range(0, 1)), r, s);
      end
      calm = 0;
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 0;

      // default sphere: poles, equator, seams and the grid edges
      send_request(KIND_VERTEX, 0, 0);
      send_request(KIND_VERTEX, 16, 32);
      send_request(KIND_VERTEX, 8, 8);
      send_request(KIND_VERTEX, 16, 0);
      send_request(KIND_VERTEX, 0, 32);
      send_request(KIND_VERTEX, 4, 8);
      send_request(KIND_VERTEX, 3, 24);
      send_request(KIND_VERTEX, 17, 0);
      send_request(KIND_VERTEX, 0, 33);
      send_request(KIND_VERTEX, 2047, 2047);
      send_request(KIND_QUAD, 0, 0);
      send_request(KIND_QUAD, 15, 31);
      send_request(KIND_QUAD, 7, 13);
      send_request(KIND_QUAD, 16, 0);
      send_request(KIND_QUAD, 0, 32);
      send_request(KIND_QUAD, 2047, 2047);
      drain();

      // receiver holds off long while requests keep coming
      long_hold = 300;
      random_items(60);
      drain();

      // counts below the minimum, largest radius
      write_csr(CSR_RADIUS, 16'hFFFF);
      write_csr(CSR_SEGMENTS, 16'd0);
      write_csr(CSR_RINGS, 16'd1);
      send_request(KIND_QUAD, 1, 2);
      send_request(KIND_VERTEX, 2, 3);
      random_items(50);
      drain();

      // largest counts and a register index that does nothing
      write_csr(CSR_RADIUS, 16'd0);
      write_csr(CSR_SEGMENTS, 16'd1024);
      write_csr(CSR_RINGS, 16'd1024);
      write_csr(CSR_SPARE, 16'h5A5A);
      send_request(KIND_QUAD, 1023, 1023);
      send_request(KIND_VERTEX, 1024, 1024);
      random_items(40);
      drain();

      // counts above the clamp
      write_csr(CSR_RADIUS, 16'h8001);
      write_csr(CSR_SEGMENTS, 16'hFFFF);
      write_csr(CSR_RINGS, 16'h07FF);
      random_items(40);
      drain();

      // random small spheres
      for (int p = 0; p < 6; p++) begin
         write_csr(CSR_RADIUS, 16'($urandom_range(0, 65535)));
         write_csr(CSR_SEGMENTS, 16'($urandom_range(0, 40)));
         write_csr(CSR_RINGS, 16'($urandom_range(0, 40)));
         random_items(45);
         drain();
      end

      if (sb.errors == 0)
         $display("[uv_sphere_mesh_generator_top] OK");
      else
         $display("[uv_sphere_mesh_generator_top] ERROR");
      $finish;
   end
endmodule

// ----- files.f -----
src/usg_pkg.sv
src/usg_div_cell.sv
src/usg_cordic_cell.sv
src/usg_out_seq.sv
src/uv_sphere_mesh_generator_top.sv
tb/tb.sv
